// File: hdl/gha_pkg.sv
`default_nettype none

package gha_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 16;
    localparam int GEN_W      = 32;
    localparam int STATUS_W   = 2;
    localparam int NEW_IDX_W  = 10;
    localparam int LIVE_W     = 11;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 56;
    localparam int M_USER_W   = 3;

    localparam logic [OP_W-1:0] OP_CREATE  = 2'd0;
    localparam logic [OP_W-1:0] OP_DESTROY = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEAD = 2'd2;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 alive;
        logic [NEW_IDX_W-1:0] new_index;
        logic [GEN_W-1:0]     new_generation;
        logic [LIVE_W-1:0]    live_count;
    } result_t;

endpackage

`default_nettype wire

// File: hdl/generational_handle_allocator_core.sv
// Generational handle allocator.
// Slave channel: one transaction per operation (create, destroy, check) with
// the handle index and generation for destroy and check. Master channel: one
// transaction per operation with status, liveness, the created handle and
// the number of live handles afterwards.
// Results are registered: an operation waits in the input stage, then its
// result moves to the output register. Throughput: one operation per cycle
// unless the receiver stalls, set by the single pass through the generation
// table read port and the free-stack top register. The generation table read
// issued at accept is bypassed from the write of the operation committing in
// the same cycle, so back-to-back operations on one slot see up-to-date generations.
// Reset clears the free depth and the high-water mark; generation entries
// below the high-water mark are written as each fresh slot is issued, so no
// clearing pass runs and the block accepts operations as soon as reset ends.
// When the receiver stalls, one finished result waits in the output register
// and one more operation is held in the input stage; tready then drops until
// the result is taken.
`default_nettype none

module generational_handle_allocator_core #(
    parameter int SLOTS = 1024
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] slot_index, [47:16] slot_generation
    input  wire logic [gha_pkg::S_DATA_W-1:0]    s_tdata,
    // [1:0] operation
    input  wire logic [gha_pkg::OP_W-1:0]        s_tuser,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [9:0] new_index, [41:10] new_generation, [52:42] live_count, [55:53] zero
    output logic [gha_pkg::M_DATA_W-1:0]         m_tdata,
    // [1:0] status, [2] alive
    output logic [gha_pkg::M_USER_W-1:0]         m_tuser
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(SLOTS);

    logic                          s1_valid_reg;
    logic [gha_pkg::OP_W-1:0]      s1_op_reg;
    logic [gha_pkg::IDX_W-1:0]     s1_idx_reg;
    logic [gha_pkg::GEN_W-1:0]     s1_gen_reg;

    logic [CW-1:0]                 free_depth_reg;
    logic [CW-1:0]                 free_depth_next;
    logic [CW-1:0]                 high_water_reg;
    logic [CW-1:0]                 high_water_next;
    logic [AW-1:0]                 tos_reg;
    logic [AW-1:0]                 tos_next;

    logic                          out_valid_reg;
    gha_pkg::result_t              out_reg;
    gha_pkg::result_t              res;

    logic [gha_pkg::GEN_W-1:0]     gen_mem [SLOTS];
    logic [gha_pkg::GEN_W-1:0]     gen_rd_reg;
    logic [AW-1:0]                 stk_mem [SLOTS];
    logic [AW-1:0]                 stk_rd_reg;

    logic                          s1_adv;
    logic                          in_acc;
    logic                          live;
    logic                          gen_we;
    logic                          gen_wr;
    logic [AW-1:0]                 gen_waddr;
    logic [gha_pkg::GEN_W-1:0]     gen_wdata;
    logic [AW-1:0]                 gen_raddr;
    logic                          stk_we;
    logic                          stk_wr;
    logic [AW-1:0]                 stk_raddr;

    logic [CW-1:0]                 eff_depth;
    logic [CW-1:0]                 eff_hw;
    logic [AW-1:0]                 eff_tos;
    logic [gha_pkg::OP_W-1:0]      in_op;
    logic [gha_pkg::IDX_W-1:0]     in_idx;
    logic [gha_pkg::GEN_W-1:0]     in_gen;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign in_acc   = s_tvalid && s_tready;

    assign in_op  = s_tuser;
    assign in_idx = s_tdata[15:0];
    assign in_gen = s_tdata[47:16];

    assign live = (32'(s1_idx_reg) < 32'(high_water_reg)) && (gen_rd_reg == s1_gen_reg);

    always_comb
    begin
        free_depth_next     = free_depth_reg;
        high_water_next     = high_water_reg;
        tos_next            = tos_reg;
        gen_we              = 1'b0;
        gen_waddr           = s1_idx_reg[AW-1:0];
        gen_wdata           = gen_rd_reg + 32'd1;
        stk_we              = 1'b0;
        res.status          = gha_pkg::ST_OK;
        res.alive           = 1'b0;
        res.new_index       = '0;
        res.new_generation  = '0;
        unique case (s1_op_reg)
            gha_pkg::OP_CREATE:
            begin
                priority if (free_depth_reg != '0)
                begin
                    free_depth_next    = free_depth_reg - CW'(1);
                    tos_next           = stk_rd_reg;
                    res.new_index      = gha_pkg::NEW_IDX_W'(tos_reg);
                    res.new_generation = gen_rd_reg;
                end
                else if (high_water_reg != SLOTS_C)
                begin
                    high_water_next = high_water_reg + CW'(1);
                    gen_we          = 1'b1;
                    gen_waddr       = high_water_reg[AW-1:0];
                    gen_wdata       = '0;
                    res.new_index   = gha_pkg::NEW_IDX_W'(high_water_reg[AW-1:0]);
                end
                else
                begin
                    res.status = gha_pkg::ST_FULL;
                end
            end
            gha_pkg::OP_DESTROY:
            begin
                if (live)
                begin
                    res.alive = 1'b1;
                    gen_we    = 1'b1;
                    if (free_depth_reg != SLOTS_C)
                    begin
                        stk_we          = 1'b1;
                        free_depth_next = free_depth_reg + CW'(1);
                        tos_next        = s1_idx_reg[AW-1:0];
                    end
                end
                else
                begin
                    res.status = gha_pkg::ST_DEAD;
                end
            end
            default:
            begin
                // check, and the unused code which behaves as check
                res.alive  = live;
                res.status = live ? gha_pkg::ST_OK : gha_pkg::ST_DEAD;
            end
        endcase
        res.live_count = (high_water_next > free_depth_next)
                       ? gha_pkg::LIVE_W'(high_water_next - free_depth_next) : '0;
    end

    assign gen_wr = s1_adv && gen_we;
    assign stk_wr = s1_adv && stk_we;

    // state as seen by the next operation
    assign eff_depth = s1_valid_reg ? free_depth_next : free_depth_reg;
    assign eff_hw    = s1_valid_reg ? high_water_next : high_water_reg;
    assign eff_tos   = s1_valid_reg ? tos_next : tos_reg;

    assign gen_raddr = (in_op == gha_pkg::OP_CREATE)
                     ? ((eff_depth != '0) ? eff_tos : eff_hw[AW-1:0])
                     : in_idx[AW-1:0];
    // entry below the top, becomes the new top on a pop
    assign stk_raddr = AW'(eff_depth - CW'(2));

    always_ff @(posedge clk)
    begin
        if (gen_wr)
        begin
            gen_mem[gen_waddr] <= gen_wdata;
        end
        if (in_acc)
        begin
            gen_rd_reg <= (gen_wr && (gen_waddr == gen_raddr)) ? gen_wdata : gen_mem[gen_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stk_wr)
        begin
            stk_mem[free_depth_reg[AW-1:0]] <= s1_idx_reg[AW-1:0];
        end
        if (in_acc)
        begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_op_reg  <= in_op;
            s1_idx_reg <= in_idx;
            s1_gen_reg <= in_gen;
        end
        if (s1_adv)
        begin
            out_reg <= res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            free_depth_reg <= '0;
            high_water_reg <= '0;
            tos_reg        <= '0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg  <= 1'b1;
                free_depth_reg <= free_depth_next;
                high_water_reg <= high_water_next;
                tos_reg        <= tos_next;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = {out_reg.alive, out_reg.status};
    assign m_tdata  = {3'b000, out_reg.live_count, out_reg.new_generation, out_reg.new_index};

    a_ready_when_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output register");

    a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_adv |=> out_valid_reg)
        else $error("committed operation produced no result");

    a_high_water_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        high_water_reg >= $past(high_water_reg))
        else $error("high-water mark decreased");

    a_pop_decrements: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && (s1_op_reg == gha_pkg::OP_CREATE) && (free_depth_reg != '0))
        |=> (free_depth_reg == $past(free_depth_reg) - CW'(1)))
        else $error("pop did not decrement free depth");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_depth_reg <= SLOTS_C)
        else $error("free depth beyond slot count");

endmodule

`default_nettype wire
